>>> hw/rtl/cdsc_pkg.sv
`timescale 1ns / 1ps
// shared types, widths and constants of the collatz descent step counter
package cdsc_pkg;

	localparam int WORK_BITS_DEF  = 128;
	localparam int START_BITS_DEF = 73;

	localparam int LOW_W  = 64;
	localparam int HIGH_W = 9;
	localparam int THR_W  = 7;
	localparam int LIM_W  = 12;
	localparam int CNT_W  = 13;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 12;

	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_STEP_LIMIT = 2'd1;

	localparam logic [THR_W-1:0] THR_RESET = 7'd71;
	localparam logic [LIM_W-1:0] LIM_RESET = 12'd2000;

	typedef struct packed {
		logic [HIGH_W-1:0] start_high;
		logic [LOW_W-1:0]  start_low;
	} in_word_t;

	typedef struct packed {
		logic [CNT_W-1:0]  step_count;
		logic              limit_hit;
		logic              overflow_hit;
		logic [CNT_W-1:0]  best_step_count;
		logic [LOW_W-1:0]  best_low;
		logic [HIGH_W-1:0] best_high;
		logic              best_valid;
	} out_word_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic step;
		logic finish;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic above;
		logic over_limit;
		logic odd_overflow;
	} status_t;

endpackage

>>> hw/rtl/cdsc_ctrl.sv
`timescale 1ns / 1ps
// controller state machine of the collatz descent step counter
module cdsc_ctrl
	import cdsc_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start_valid,
	output logic    start_stall,
	output logic    result_valid,
	input  logic    result_stall,
	input  status_t status,
	output cmd_t    cmd
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_RUN  = 1'b1;

	logic state_q;
	logic out_valid_q;
	logic slot_free;
	logic done;

	assign start_stall  = (state_q != ST_IDLE);
	assign result_valid = out_valid_q;

	// result register can take a word when empty or drained this cycle
	assign slot_free = !out_valid_q || !result_stall;
	assign done      = !status.above || status.over_limit || status.odd_overflow;

	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_IDLE: begin
				cmd.load = start_valid;
			end
			ST_RUN: begin
				cmd.step   = !done;
				cmd.finish = done && slot_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				state_q <= ST_RUN;
			end else if (cmd.finish) begin
				state_q <= ST_IDLE;
			end
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

>>> hw/rtl/cdsc_dp.sv
`timescale 1ns / 1ps
// datapath of the collatz descent step counter: map step, counter, best record
module cdsc_dp
	import cdsc_pkg::*;
#(
	parameter int WORK_BITS  = WORK_BITS_DEF,
	parameter int START_BITS = START_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  in_word_t              start,
	input  cmd_t                  cmd,
	output status_t               status,
	output out_word_t             result
);

	localparam int SH_W = START_BITS - LOW_W;

	logic [THR_W-1:0]     thr_q;
	logic [LIM_W-1:0]     limit_q;
	logic [WORK_BITS-1:0] x_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [LOW_W-1:0]     start_low_q;
	logic [HIGH_W-1:0]    start_high_q;
	logic [CNT_W-1:0]     best_cnt_q;
	logic [LOW_W-1:0]     best_low_q;
	logic [HIGH_W-1:0]    best_high_q;
	logic                 best_seen_q;
	out_word_t            res_q;

	logic [WORK_BITS-1:0] thr_mask;
	logic [WORK_BITS+1:0] triple;
	logic                 odd;
	logic                 lim_flag;
	logic                 ovf_flag;
	logic                 take_best;
	logic [CNT_W-1:0]     best_cnt_d;
	logic [LOW_W-1:0]     best_low_d;
	logic [HIGH_W-1:0]    best_high_d;

	// bit i is set when i is at or above the threshold
	always_comb begin
		for (int i = 0; i < WORK_BITS; i++) begin
			thr_mask[i] = ({1'b0, thr_q} <= 8'(i));
		end
	end

	assign odd    = x_q[0];
	assign triple = {2'b00, x_q} + {1'b0, x_q, 1'b0} + (WORK_BITS+2)'(1);

	assign status.above        = |(x_q & thr_mask);
	assign status.over_limit   = (cnt_q > {1'b0, limit_q});
	assign status.odd_overflow = odd && (|triple[WORK_BITS+1:WORK_BITS]);

	assign lim_flag  = status.above && status.over_limit;
	assign ovf_flag  = status.above && !status.over_limit && status.odd_overflow;
	assign take_best = !lim_flag && !ovf_flag && (!best_seen_q || (cnt_q > best_cnt_q));

	assign best_cnt_d  = take_best ? cnt_q        : best_cnt_q;
	assign best_low_d  = take_best ? start_low_q  : best_low_q;
	assign best_high_d = take_best ? start_high_q : best_high_q;

	assign result = res_q;

	// configuration and best record
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q       <= THR_RESET;
			limit_q     <= LIM_RESET;
			best_cnt_q  <= '0;
			best_low_q  <= '0;
			best_high_q <= '0;
			best_seen_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_THRESHOLD:  thr_q   <= cfg_data[THR_W-1:0];
					REG_STEP_LIMIT: limit_q <= cfg_data[LIM_W-1:0];
					default:        ;
				endcase
			end
			if (cmd.finish) begin
				best_cnt_q  <= best_cnt_d;
				best_low_q  <= best_low_d;
				best_high_q <= best_high_d;
				best_seen_q <= best_seen_q || take_best;
			end
		end
	end

	// working value, counter and result word
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x_q          <= WORK_BITS'({start.start_high[SH_W-1:0], start.start_low});
			cnt_q        <= '0;
			start_low_q  <= start.start_low;
			start_high_q <= HIGH_W'(start.start_high[SH_W-1:0]);
		end else if (cmd.step) begin
			if (odd) begin
				x_q <= triple[WORK_BITS:1];
			end else begin
				x_q <= {1'b0, x_q[WORK_BITS-1:1]};
			end
			cnt_q <= cnt_q + CNT_W'(1);
		end
		if (cmd.finish) begin
			res_q.step_count      <= cnt_q;
			res_q.limit_hit       <= lim_flag;
			res_q.overflow_hit    <= ovf_flag;
			res_q.best_step_count <= best_cnt_d;
			res_q.best_low        <= best_low_d;
			res_q.best_high       <= best_high_d;
			res_q.best_valid      <= best_seen_q || take_best;
		end
	end

endmodule

>>> hw/rtl/collatz_descent_step_counter.sv
`timescale 1ns / 1ps
// result word: registered when a run finishes; the finish waits while the output holds a stalled word
// a new start is taken only after the previous run has finished; the step limit goes up to 4095
// the single map-step unit (three-x-plus-one adder and threshold test) sets the pace
// the next start is taken while the previous result word still waits at the output
// reset: async active low, threshold 71, step limit 2000, best record cleared, no clearing pass
module collatz_descent_step_counter
	import cdsc_pkg::*;
#(
	parameter int WORK_BITS  = WORK_BITS_DEF,
	parameter int START_BITS = START_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// start words
	input  logic                  start_valid,
	output logic                  start_stall,
	input  in_word_t              start,
	// result words
	output logic                  result_valid,
	input  logic                  result_stall,
	output out_word_t             result,
	// configuration writes
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cmd_t    cmd;
	status_t status;

	// registers are plain flops, a write is always accepted
	assign cfg_ready = 1'b1;

	// sequencer: idle, iterate, hand the result to the output register
	cdsc_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.start_valid  (start_valid),
		.start_stall  (start_stall),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.status       (status),
		.cmd          (cmd)
	);

	// working value, step counter, best record and result word
	cdsc_dp #(
		.WORK_BITS  (WORK_BITS),
		.START_BITS (START_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.start     (start),
		.cmd       (cmd),
		.status    (status),
		.result    (result)
	);

	// an accepted start always keeps the input stalled on the next clock
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		start_valid && !start_stall |=> start_stall)
		else $error("input not stalled after start accepted");

	// a run stops for one reason only
	a_one_flag: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !(result.limit_hit && result.overflow_hit))
		else $error("limit and overflow both flagged");

	// an unflagged result always leaves a record at least as long
	a_best_covers: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.limit_hit && !result.overflow_hit |->
			result.best_valid && (result.best_step_count >= result.step_count))
		else $error("best record behind an unflagged result");

	// no two controller commands in the same cycle
	a_cmd_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.step && cmd.finish) && !(cmd.load && (cmd.step || cmd.finish)))
		else $error("overlapping controller commands");

endmodule
